>>> rtl/lru_pr_pkg.sv
// Package for the LRU page replacement unit: frame count, page width,
// rank and index widths, and the shared scalar types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lru_pr_pkg;

   localparam int FRAMES        = 8;
   localparam int PAGE_BITS     = 16;
   localparam int IDX_W         = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int RANK_W        = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CAP_W         = $clog2(FRAMES + 1);
   localparam int CSR_W         = 4;
   localparam int FRAME_OUT_W   = 3;
   localparam int FAULT_W       = 32;

   typedef logic [PAGE_BITS-1:0] page_type;
   typedef logic [RANK_W-1:0]    rank_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CAP_W-1:0]     cap_type;
   typedef logic [FAULT_W-1:0]   fault_type;
   typedef logic [CSR_W-1:0]     csr_type;

   localparam csr_type   CSR_RESET = csr_type'(3);
   localparam rank_type  RANK_MAX  = rank_type'(FRAMES - 1);
   localparam fault_type FAULT_MAX = '1;

endpackage

`default_nettype wire

>>> rtl/lru_page_replacement_unit.sv
// LRU page replacement unit: one page reference in, one replacement result out.
// Depends on lru_pr_pkg for the frame count, widths and types.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------------
//   req     | in        | req_valid/req_ready | req_page_number, req_last_of_run
//   rsp     | out       | rsp_valid/rsp_ready | rsp_hit, rsp_frame_index,
//           |           |                     | rsp_evicted_valid, rsp_evicted_page,
//           |           |                     | rsp_fault_count
//   csr     | in        | csr_we (no wait)    | csr_wdata -> frames_in_use
//
// Cycles: resolve a request while it sits in the input register and register
// its result at the next edge; one request per cycle is sustained while rsp_ready is high.
// Reset (synchronous, active high) empties the frames, clears ranks and the
// fault count, and sets frames_in_use to 3. Page contents are not reset.
// Stalls: a result waiting on rsp_ready holds the input register; req_ready
// drops only when both the input and result registers are full and held.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_replacement_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [lru_pr_pkg::PAGE_BITS-1:0]    req_page_number,
   input  wire logic                                req_last_of_run,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_hit,
   output logic [lru_pr_pkg::FRAME_OUT_W-1:0]       rsp_frame_index,
   output logic                                     rsp_evicted_valid,
   output logic [lru_pr_pkg::PAGE_BITS-1:0]         rsp_evicted_page,
   output logic [lru_pr_pkg::FAULT_W-1:0]           rsp_fault_count,
   // configuration
   input  wire logic                                csr_we,
   input  wire logic [lru_pr_pkg::CSR_W-1:0]        csr_wdata
);

   // Configuration
   lru_pr_pkg::csr_type   frames_in_use_ff;

   // Input register
   logic                  in_valid_ff, in_valid_in;
   lru_pr_pkg::page_type  in_page_ff;
   logic                  in_last_ff;

   // Frame state
   lru_pr_pkg::page_type  frame_page_ff [lru_pr_pkg::FRAMES];
   logic [lru_pr_pkg::FRAMES-1:0] frame_valid_ff, frame_valid_in;
   lru_pr_pkg::rank_type  rank_ff [lru_pr_pkg::FRAMES];
   lru_pr_pkg::rank_type  rank_in [lru_pr_pkg::FRAMES];
   lru_pr_pkg::fault_type faults_ff, faults_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff;
   logic [lru_pr_pkg::FRAME_OUT_W-1:0] rsp_frame_ff;
   logic                  rsp_evicted_ff;
   lru_pr_pkg::page_type  rsp_evicted_page_ff;
   lru_pr_pkg::fault_type rsp_fault_ff;

   // Resolve logic
   logic                  req_accept;
   logic                  advance;
   lru_pr_pkg::cap_type   cap_c;
   logic [lru_pr_pkg::FRAMES-1:0] in_cap_c;
   logic                  hit_c;
   lru_pr_pkg::idx_type   hit_idx_c;
   logic                  have_empty_c;
   lru_pr_pkg::idx_type   empty_idx_c;
   lru_pr_pkg::rank_type  best_rank_c;
   lru_pr_pkg::idx_type   lru_idx_c;
   lru_pr_pkg::idx_type   sel_idx_c;
   logic [lru_pr_pkg::RANK_W:0] old_rank_c;
   logic                  evict_c;
   lru_pr_pkg::fault_type fault_next_c;

   // Handshake: the input register advances whenever the result register
   // is empty or being emptied this cycle.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Effective capacity: zero acts as one, anything above the frame count
   // clamps to it.
   always_comb begin
      if (int'(frames_in_use_ff) > lru_pr_pkg::FRAMES) begin
         cap_c = lru_pr_pkg::cap_type'(lru_pr_pkg::FRAMES);
      end else if (frames_in_use_ff == '0) begin
         cap_c = lru_pr_pkg::cap_type'(1);
      end else begin
         cap_c = lru_pr_pkg::cap_type'(frames_in_use_ff);
      end
      for (int g = 0; g < lru_pr_pkg::FRAMES; g++) begin
         in_cap_c[g] = lru_pr_pkg::cap_type'(g) < cap_c;
      end
   end

   // Parallel tag compare, lowest-indexed empty frame, and the oldest frame
   // (lowest index wins among equal oldest ranks).
   always_comb begin
      hit_c        = 1'b0;
      hit_idx_c    = '0;
      have_empty_c = 1'b0;
      empty_idx_c  = '0;
      best_rank_c  = '0;
      lru_idx_c    = '0;
      for (int g = 0; g < lru_pr_pkg::FRAMES; g++) begin
         if (!hit_c && in_cap_c[g] && frame_valid_ff[g] &&
             (frame_page_ff[g] == in_page_ff)) begin
            hit_c     = 1'b1;
            hit_idx_c = lru_pr_pkg::idx_type'(g);
         end
         if (!have_empty_c && in_cap_c[g] && !frame_valid_ff[g]) begin
            have_empty_c = 1'b1;
            empty_idx_c  = lru_pr_pkg::idx_type'(g);
         end
         if (in_cap_c[g] && (rank_ff[g] > best_rank_c)) begin
            best_rank_c = rank_ff[g];
            lru_idx_c   = lru_pr_pkg::idx_type'(g);
         end
      end
   end

   // Pick the frame and the rank it leaves behind; a fill into an empty frame
   // ages every valid in-capacity frame not already at the maximum rank.
   always_comb begin
      evict_c = 1'b0;
      if (hit_c) begin
         sel_idx_c  = hit_idx_c;
         old_rank_c = {1'b0, rank_ff[hit_idx_c]};
      end else if (have_empty_c) begin
         sel_idx_c  = empty_idx_c;
         old_rank_c = {1'b0, lru_pr_pkg::RANK_MAX} + 1'b1;
      end else begin
         sel_idx_c  = lru_idx_c;
         old_rank_c = {1'b0, rank_ff[lru_idx_c]};
         evict_c    = 1'b1;
      end
      if (!hit_c && (faults_ff != lru_pr_pkg::FAULT_MAX)) begin
         fault_next_c = faults_ff + 1'b1;
      end else begin
         fault_next_c = faults_ff;
      end
   end

   // Next frame state: age younger frames, zero the touched one, mark the
   // fill valid, then wipe the run if this was its last request.
   always_comb begin
      frame_valid_in = frame_valid_ff;
      faults_in      = faults_ff;
      for (int g = 0; g < lru_pr_pkg::FRAMES; g++) begin
         rank_in[g] = rank_ff[g];
      end
      if (advance) begin
         for (int g = 0; g < lru_pr_pkg::FRAMES; g++) begin
            if (in_cap_c[g] && (lru_pr_pkg::idx_type'(g) != sel_idx_c) &&
                frame_valid_ff[g] && ({1'b0, rank_ff[g]} < old_rank_c) &&
                (rank_ff[g] != lru_pr_pkg::RANK_MAX)) begin
               rank_in[g] = rank_ff[g] + 1'b1;
            end
         end
         rank_in[sel_idx_c] = '0;
         frame_valid_in[sel_idx_c] = 1'b1;
         faults_in = fault_next_c;
         if (in_last_ff) begin
            frame_valid_in = '0;
            faults_in      = '0;
            for (int g = 0; g < lru_pr_pkg::FRAMES; g++) begin
               rank_in[g] = '0;
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= lru_pr_pkg::CSR_RESET;
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         frame_valid_ff   <= '0;
         faults_ff        <= '0;
         for (int g = 0; g < lru_pr_pkg::FRAMES; g++) begin
            rank_ff[g] <= '0;
         end
      end else begin
         if (csr_we) begin
            frames_in_use_ff <= csr_wdata;
         end
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         frame_valid_ff <= frame_valid_in;
         faults_ff      <= faults_in;
         for (int g = 0; g < lru_pr_pkg::FRAMES; g++) begin
            rank_ff[g] <= rank_in[g];
         end
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_page_ff <= req_page_number;
         in_last_ff <= req_last_of_run;
      end
      if (advance && !hit_c) begin
         frame_page_ff[sel_idx_c] <= in_page_ff;
      end
      if (advance) begin
         rsp_hit_ff          <= hit_c;
         rsp_frame_ff        <= lru_pr_pkg::FRAME_OUT_W'(sel_idx_c);
         rsp_evicted_ff      <= evict_c;
         rsp_evicted_page_ff <= evict_c ? frame_page_ff[sel_idx_c] : '0;
         rsp_fault_ff        <= fault_next_c;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_evicted_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   assign rsp_fault_count   = rsp_fault_ff;

   // A last-of-run request leaves an empty run behind.
   a_run_clear : assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> (frame_valid_ff == '0) && (faults_ff == '0))
      else $error("run not cleared after last request");

   // Frames and fault count change only when a request is resolved.
   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(frame_valid_ff) && $stable(faults_ff))
      else $error("frame state changed without a request");

   // A hit never evicts and never counts a fault.
   a_hit_clean : assert property (@(posedge clock) disable iff (reset)
      advance && hit_c && !in_last_ff |=>
         rsp_hit && !rsp_evicted_valid && (faults_ff == $past(faults_ff)))
      else $error("hit evicted or counted a fault");

   // Eviction only happens with every in-capacity frame occupied.
   a_evict_full : assert property (@(posedge clock) disable iff (reset)
      advance && evict_c |-> ((frame_valid_ff & in_cap_c) == in_cap_c))
      else $error("eviction with an empty frame available");

endmodule

`default_nettype wire
